FILE: rtl/hrd_pkg.sv
// shared types, codes and string lookups for the http response deframer
// no dependencies
package hrd_pkg;

   typedef enum logic [3:0] {
      PH_PROTO, PH_VERSION, PH_STATUS, PH_DESC, PH_KEY, PH_VALUE,
      PH_BODY, PH_CLEN, PH_CDATA, PH_CTRAIL, PH_DONE
   } phase_type;

   typedef enum logic [2:0] {
      EV_BODY = 3'd0, EV_LAST = 3'd1, EV_STATUS = 3'd2, EV_HDR_DONE = 3'd3,
      EV_NO_DATA = 3'd4
   } event_type;

   localparam logic [2:0] NM_CONN = 3'b001;
   localparam logic [2:0] NM_TE   = 3'b010;
   localparam logic [2:0] NM_CL   = 3'b100;

   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_SLASH = 8'h2f;
   localparam logic [7:0] CH_COLON = 8'h3a;
   localparam logic [7:0] CH_H     = 8'h68;

   localparam logic [4:0] LEN_CONN    = 5'd10;
   localparam logic [4:0] LEN_TE      = 5'd17;
   localparam logic [4:0] LEN_CL      = 5'd14;
   localparam logic [4:0] LEN_CLOSE   = 5'd5;
   localparam logic [4:0] LEN_CHUNKED = 5'd7;
   localparam logic [4:0] LEN_HTTP    = 5'd4;
   localparam logic [4:0] POS_MAX     = 5'd31;

   // classified byte handed from front to back
   typedef struct packed {
      logic [7:0] data;
      logic [7:0] lc;
      logic       is_digit;
      logic       is_hex;
      logic [3:0] hex_val;
   } cls_type;

   function automatic logic [7:0] conn_chr(input logic [4:0] p);
      case (p)
         5'd0: conn_chr = "c";  5'd1: conn_chr = "o";  5'd2: conn_chr = "n";
         5'd3: conn_chr = "n";  5'd4: conn_chr = "e";  5'd5: conn_chr = "c";
         5'd6: conn_chr = "t";  5'd7: conn_chr = "i";  5'd8: conn_chr = "o";
         5'd9: conn_chr = "n";
         default: conn_chr = 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] te_chr(input logic [4:0] p);
      case (p)
         5'd0: te_chr = "t";   5'd1: te_chr = "r";   5'd2: te_chr = "a";
         5'd3: te_chr = "n";   5'd4: te_chr = "s";   5'd5: te_chr = "f";
         5'd6: te_chr = "e";   5'd7: te_chr = "r";   5'd8: te_chr = "-";
         5'd9: te_chr = "e";   5'd10: te_chr = "n";  5'd11: te_chr = "c";
         5'd12: te_chr = "o";  5'd13: te_chr = "d";  5'd14: te_chr = "i";
         5'd15: te_chr = "n";  5'd16: te_chr = "g";
         default: te_chr = 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] cl_chr(input logic [4:0] p);
      case (p)
         5'd0: cl_chr = "c";   5'd1: cl_chr = "o";   5'd2: cl_chr = "n";
         5'd3: cl_chr = "t";   5'd4: cl_chr = "e";   5'd5: cl_chr = "n";
         5'd6: cl_chr = "t";   5'd7: cl_chr = "-";   5'd8: cl_chr = "l";
         5'd9: cl_chr = "e";   5'd10: cl_chr = "n";  5'd11: cl_chr = "g";
         5'd12: cl_chr = "t";  5'd13: cl_chr = "h";
         default: cl_chr = 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] close_chr(input logic [4:0] p);
      case (p)
         5'd0: close_chr = "c";  5'd1: close_chr = "l";  5'd2: close_chr = "o";
         5'd3: close_chr = "s";  5'd4: close_chr = "e";
         default: close_chr = 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] chunked_chr(input logic [4:0] p);
      case (p)
         5'd0: chunked_chr = "c";  5'd1: chunked_chr = "h";  5'd2: chunked_chr = "u";
         5'd3: chunked_chr = "n";  5'd4: chunked_chr = "k";  5'd5: chunked_chr = "e";
         5'd6: chunked_chr = "d";
         default: chunked_chr = 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] http_chr(input logic [4:0] p);
      case (p)
         5'd0: http_chr = "h";  5'd1: http_chr = "t";  5'd2: http_chr = "t";
         5'd3: http_chr = "p";
         default: http_chr = 8'h00;
      endcase
   endfunction

   function automatic logic [4:0] pos_inc(input logic [4:0] p);
      pos_inc = (p < POS_MAX) ? p + 5'd1 : POS_MAX;
   endfunction

endpackage

FILE: rtl/hrd_front.sv
// front stage: accepts raw bytes, lowercases and classifies them
// depends on hrd_pkg
module hrd_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic [7:0]      req_data_byte,
   output logic            f_valid,
   input  logic            f_ready,
   output hrd_pkg::cls_type f_cls
);
   import hrd_pkg::*;

   logic    vld_ff, vld_in;
   cls_type cls_ff, cls_in;
   logic [7:0] lc;

   assign req_ready = !vld_ff || f_ready;

   always_comb begin
      lc = (req_data_byte >= "A" && req_data_byte <= "Z") ?
           req_data_byte + 8'd32 : req_data_byte;
      cls_in.data     = req_data_byte;
      cls_in.lc       = lc;
      cls_in.is_digit = (req_data_byte >= "0" && req_data_byte <= "9");
      cls_in.is_hex   = cls_in.is_digit || (lc >= "a" && lc <= "f");
      cls_in.hex_val  = cls_in.is_digit ? req_data_byte[3:0] : lc[3:0] + 4'd9;
      vld_in = vld_ff;
      if (req_ready) begin
         vld_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      if (req_valid && req_ready) begin
         cls_ff <= cls_in;
      end
   end

   assign f_valid = vld_ff;
   assign f_cls   = cls_ff;
endmodule

FILE: rtl/hrd_queue.sv
// two-entry queue of classified bytes between front and back
// depends on hrd_pkg
module hrd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  hrd_pkg::cls_type push_cls,
   output logic             pop_valid,
   input  logic             pop_ready,
   output hrd_pkg::cls_type pop_cls
);
   import hrd_pkg::*;

   cls_type    mem_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign push_ready = (cnt_ff != 2'd2);
   assign pop_valid  = (cnt_ff != 2'd0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_cls    = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (pop) rd_ff <= !rd_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) begin
         mem_ff[wr_ff] <= push_cls;
      end
   end
endmodule

FILE: rtl/hrd_back.sv
// back end: protocol walker, header matcher, body framer and result register
// depends on hrd_pkg
module hrd_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   output logic             q_ready,
   input  hrd_pkg::cls_type q_cls,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [2:0]       rsp_event_res,
   output logic [7:0]       rsp_body_byte,
   output logic [9:0]       rsp_status_code,
   output logic [31:0]      rsp_body_len,
   output logic             rsp_chunked_mode,
   output logic             rsp_persist
);
   import hrd_pkg::*;

   phase_type   ph_ff, ph_in;
   logic [9:0]  st_ff, st_in;
   logic [2:0]  nc_ff, nc_in;
   logic [4:0]  tp_ff, tp_in;
   logic [1:0]  vc_ff, vc_in;
   logic        vs_ff, vs_in;
   logic        cr_ff, cr_in;
   logic [31:0] len_ff, len_in;
   logic [31:0] rc_ff, rc_in;
   logic [31:0] cs_ff, cs_in;
   logic [1:0]  fl_ff, fl_in;

   logic        ov_ff;
   event_type   oev_ff, ev;
   logic [7:0]  ob_ff, eb;
   logic [9:0]  ost_ff;
   logic [31:0] olen_ff;
   logic [1:0]  ofl_ff;
   logic        emit, step;

   logic [7:0]  c, lc;
   logic [2:0]  nk;
   logic [4:0]  tpw;
   logic [13:0] st_mul;
   logic [35:0] len_mul;
   logic [31:0] rc_inc;
   logic [2:0]  full;

   assign q_ready = !ov_ff || rsp_ready;
   assign step    = q_valid && q_ready;

   always_comb begin
      ph_in = ph_ff; st_in = st_ff; nc_in = nc_ff; tp_in = tp_ff;
      vc_in = vc_ff; vs_in = vs_ff; cr_in = cr_ff; len_in = len_ff;
      rc_in = rc_ff; cs_in = cs_ff; fl_in = fl_ff;
      emit = 1'b0; ev = EV_BODY; eb = 8'h00;
      c = q_cls.data; lc = q_cls.lc;
      nk = 3'b000; tpw = tp_ff; full = 3'b000;
      st_mul  = {4'b0, st_ff} * 14'd10 + {10'b0, c[3:0]};
      len_mul = ({4'b0, len_ff} << 3) + ({4'b0, len_ff} << 1) + {32'b0, c[3:0]};
      rc_inc  = rc_ff + 32'd1;
      case (ph_ff)
         PH_PROTO: begin
            if (c == CH_SLASH) begin
               ph_in = (tp_ff == LEN_HTTP) ? PH_VERSION : PH_STATUS;
               tp_in = 5'd0;
            end else if (tp_ff < LEN_HTTP && lc == http_chr(tp_ff)) begin
               tp_in = tp_ff + 5'd1;
            end else begin
               tp_in = (lc == CH_H) ? 5'd1 : 5'd0;
            end
         end
         PH_VERSION: begin
            if (c == CH_SPACE) begin
               ph_in = PH_STATUS; tp_in = 5'd0;
            end
         end
         PH_STATUS: begin
            if (c == CH_SPACE) begin
               ph_in = PH_DESC; tp_in = 5'd0; cr_in = 1'b0;
               emit = 1'b1; ev = EV_STATUS;
            end else if (tp_ff == 5'd0 && q_cls.is_digit) begin
               st_in = (st_mul > 14'd999) ? 10'd999 : st_mul[9:0];
            end else begin
               tp_in = 5'd1;
            end
         end
         PH_DESC: begin
            if (cr_ff && c == CH_LF) begin
               ph_in = PH_KEY; nc_in = 3'b111; tp_in = 5'd0; cr_in = 1'b0;
            end else begin
               cr_in = (c == CH_CR);
            end
         end
         PH_KEY: begin
            if (cr_ff && c == CH_LF) begin
               cr_in = 1'b0; rc_in = 32'd0; cs_in = 32'd0;
               ph_in = fl_ff[0] ? PH_CLEN : PH_BODY;
               emit = 1'b1; ev = EV_HDR_DONE;
            end else if (!cr_ff && c == CH_CR && tp_ff == 5'd0) begin
               cr_in = 1'b1;
            end else begin
               // a lone cr inside a name kills every candidate
               nk = cr_ff ? 3'b000 : nc_ff;
               tpw = cr_ff ? pos_inc(tp_ff) : tp_ff;
               cr_in = 1'b0;
               if (c == CH_COLON) begin
                  if (nk[0] && tpw == LEN_CONN) full = NM_CONN;
                  if (nk[1] && tpw == LEN_TE) full = NM_TE;
                  if (nk[2] && tpw == LEN_CL) full = NM_CL;
                  nc_in = full;
                  if (full == NM_CL) len_in = 32'd0;
                  vc_in = 2'b11; vs_in = 1'b0; tp_in = 5'd0;
                  ph_in = PH_VALUE;
               end else begin
                  nc_in[0] = nk[0] && tpw < LEN_CONN && lc == conn_chr(tpw);
                  nc_in[1] = nk[1] && tpw < LEN_TE && lc == te_chr(tpw);
                  nc_in[2] = nk[2] && tpw < LEN_CL && lc == cl_chr(tpw);
                  tp_in = pos_inc(tpw);
               end
            end
         end
         PH_VALUE: begin
            if (cr_ff && c == CH_LF) begin
               if (nc_ff[0]) begin
                  fl_in[1] = !(vc_ff[0] && tp_ff == LEN_CLOSE);
               end else if (nc_ff[1]) begin
                  if (vc_ff[1] && tp_ff == LEN_CHUNKED) fl_in[0] = 1'b1;
               end
               ph_in = PH_KEY; nc_in = 3'b111; tp_in = 5'd0; cr_in = 1'b0;
            end else begin
               // a lone cr inside a value fails every match
               tpw = cr_ff ? pos_inc(tp_ff) : tp_ff;
               vc_in = cr_ff ? 2'b00 : vc_ff;
               vs_in = vs_ff || cr_ff;
               tp_in = tpw;
               cr_in = 1'b0;
               if (c == CH_CR) begin
                  cr_in = 1'b1;
               end else if (c == CH_SPACE && !vs_in) begin
                  vs_in = 1'b0;
               end else begin
                  vs_in = 1'b1;
                  if (nc_ff[2]) begin
                     if (vc_in[0] && q_cls.is_digit) begin
                        len_in = (len_mul[35:32] != 4'd0) ? 32'hFFFF_FFFF : len_mul[31:0];
                     end else begin
                        vc_in = 2'b00;
                     end
                  end else begin
                     vc_in[0] = vc_in[0] && tpw < LEN_CLOSE && lc == close_chr(tpw);
                     vc_in[1] = vc_in[1] && tpw < LEN_CHUNKED && lc == chunked_chr(tpw);
                  end
                  tp_in = pos_inc(tpw);
               end
            end
         end
         PH_BODY: begin
            emit = 1'b1; eb = c;
            if (len_ff != 32'd0) begin
               rc_in = rc_inc;
               if (rc_inc >= len_ff) begin
                  ph_in = PH_DONE; ev = EV_LAST;
               end
            end
         end
         PH_CLEN: begin
            if (cr_ff && c == CH_LF) begin
               cr_in = 1'b0;
               if (cs_ff == 32'd0) begin
                  ph_in = PH_DONE; emit = 1'b1; ev = EV_NO_DATA;
               end else begin
                  rc_in = 32'd0; ph_in = PH_CDATA;
               end
            end else begin
               cr_in = (c == CH_CR);
               if (q_cls.is_hex) begin
                  cs_in = (cs_ff > 32'h0FFF_FFFF) ? 32'hFFFF_FFFF :
                          {cs_ff[27:0], q_cls.hex_val};
               end
            end
         end
         PH_CDATA: begin
            rc_in = rc_inc; emit = 1'b1; eb = c;
            if (rc_inc >= cs_ff) begin
               ph_in = PH_CTRAIL; tp_in = 5'd0;
            end
         end
         PH_CTRAIL: begin
            tp_in = tp_ff + 5'd1;
            if (tp_ff >= 5'd1) begin
               tp_in = 5'd0; cs_in = 32'd0; cr_in = 1'b0; ph_in = PH_CLEN;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= PH_PROTO; st_ff <= 10'd0; nc_ff <= 3'b111; tp_ff <= 5'd0;
         vc_ff <= 2'b11; vs_ff <= 1'b0; cr_ff <= 1'b0; len_ff <= 32'd0;
         rc_ff <= 32'd0; cs_ff <= 32'd0; fl_ff <= 2'b00; ov_ff <= 1'b0;
      end else begin
         if (step) begin
            ph_ff <= ph_in; st_ff <= st_in; nc_ff <= nc_in; tp_ff <= tp_in;
            vc_ff <= vc_in; vs_ff <= vs_in; cr_ff <= cr_in; len_ff <= len_in;
            rc_ff <= rc_in; cs_ff <= cs_in; fl_ff <= fl_in;
         end
         if (q_ready) begin
            ov_ff <= step && emit;
         end
      end
      if (step && emit) begin
         oev_ff <= ev; ob_ff <= eb; ost_ff <= st_ff; olen_ff <= len_ff;
         ofl_ff <= fl_ff;
      end
   end

   assign rsp_valid        = ov_ff;
   assign rsp_event_res    = oev_ff;
   assign rsp_body_byte    = ob_ff;
   assign rsp_status_code  = ost_ff;
   assign rsp_body_len     = olen_ff;
   assign rsp_chunked_mode = ofl_ff[0];
   assign rsp_persist      = ofl_ff[1];
endmodule

FILE: rtl/http_response_deframer_top.sv
// top level of the http response deframer: front classifier, queue, back parser
// depends on hrd_pkg, hrd_front, hrd_queue, hrd_back
//
//   channel | direction | beat contents
//   req_    | in        | data_byte, segment_last (segment_last has no effect)
//   rsp_    | out       | event_res, body_byte, status_code, body_len,
//           |           | chunked_mode, persist
//
// one byte per cycle sustained while rsp_ready holds; each byte passes
// through the front register and the queue, and is parsed as it leaves the
// queue, its result landing in the output register
// synchronous active-high reset returns the parser to the protocol step
// a stalled rsp_ready fills the output register, then the queue, then the front
// register, and only then drops req_ready
module http_response_deframer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_segment_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_event_res,
   output logic [7:0]  rsp_body_byte,
   output logic [9:0]  rsp_status_code,
   output logic [31:0] rsp_body_len,
   output logic        rsp_chunked_mode,
   output logic        rsp_persist
);
   import hrd_pkg::*;

   // front to queue
   logic    f_valid, f_ready;
   cls_type f_cls;
   // queue to back
   logic    q_valid, q_ready;
   cls_type q_cls;
   logic    seg_unused;

   // segment boundaries do not matter to the parse
   assign seg_unused = req_segment_last;

   hrd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .f_valid       (f_valid),
      .f_ready       (f_ready),
      .f_cls         (f_cls)
   );

   hrd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_cls   (f_cls),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_cls    (q_cls)
   );

   hrd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_ready          (q_ready),
      .q_cls            (q_cls),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_event_res    (rsp_event_res),
      .rsp_body_byte    (rsp_body_byte),
      .rsp_status_code  (rsp_status_code),
      .rsp_body_len     (rsp_body_len),
      .rsp_chunked_mode (rsp_chunked_mode),
      .rsp_persist      (rsp_persist)
   );

`ifndef SYNTHESIS
   // nothing comes out in the cycle after reset
   a_rst_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // the front register only blocks input when it holds a byte
   a_front_hold: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> f_valid)
      else $error("input stalled with empty front");

   // status, header-done and no-data events never carry a body byte
   a_ctrl_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_event_res == EV_STATUS || rsp_event_res == EV_HDR_DONE ||
                     rsp_event_res == EV_NO_DATA)) |-> rsp_body_byte == 8'h00)
      else $error("control event with body byte");

   // a queue that refuses a push is never empty: it always has a byte to pop
   a_queue_full: assert property (@(posedge clock) disable iff (reset)
      !f_ready |-> q_valid)
      else $error("queue refuses push while empty");
`endif
endmodule

FILE: dv/tb.sv
// testbench for the http response deframer: byte stream in, parse events out
// depends on hrd_pkg and http_response_deframer_top
// a built-in parser model predicts each event; results are checked in order
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import hrd_pkg::*;

   typedef struct {
      logic [2:0]  ev;
      logic [7:0]  body;
      logic [9:0]  status;
      logic [31:0] clen;
      logic        chunked;
      logic        keep;
   } parse_event_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_segment_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_event_res;
   logic [7:0]  rsp_body_byte;
   logic [9:0]  rsp_status_code;
   logic [31:0] rsp_body_len;
   logic        rsp_chunked_mode;
   logic        rsp_persist;

   http_response_deframer_top dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // pending response bytes {segment_last, byte} and expected parse events
   logic [8:0]      byte_queue[$];
   parse_event_type event_queue[$];
   int              failures = 0;
   longint          cycle_count = 0;
   bit              long_hold = 0;
   bit              sent_flag = 0;

   // parser model state
   phase_type   m_phase;
   logic [9:0]  m_status;
   logic [2:0]  m_names;
   logic [4:0]  m_pos;
   logic [1:0]  m_vals;
   logic        m_started, m_cr;
   logic [31:0] m_len, m_count, m_chunk;
   logic        m_chunked, m_keep;

   function automatic logic [7:0] to_lower(logic [7:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
   endfunction

   function automatic logic [4:0] bump(logic [4:0] p);
      return (p < 5'd31) ? p + 5'd1 : 5'd31;
   endfunction

   function automatic bit char_at(string s, logic [4:0] p, logic [7:0] c);
      return p < s.len() && to_lower(c) == s[p];
   endfunction

   task automatic model_clear();
      m_phase = PH_PROTO; m_status = 0; m_names = 3'b111; m_pos = 0; m_vals = 2'b11;
      m_started = 0; m_cr = 0; m_len = 0; m_count = 0; m_chunk = 0;
      m_chunked = 0; m_keep = 0;
   endtask

   task automatic push_event(logic [2:0] ev, logic [7:0] b);
      parse_event_type e;
      e.ev = ev; e.body = b; e.status = m_status; e.clen = m_len;
      e.chunked = m_chunked; e.keep = m_keep;
      event_queue.push_back(e);
   endtask

   task automatic name_step(logic [7:0] c);
      logic [2:0] k;
      k = 0;
      if (m_names[0] && char_at("connection", m_pos, c)) k[0] = 1;
      if (m_names[1] && char_at("transfer-encoding", m_pos, c)) k[1] = 1;
      if (m_names[2] && char_at("content-length", m_pos, c)) k[2] = 1;
      m_names = k;
      m_pos = bump(m_pos);
   endtask

   task automatic value_step(logic [7:0] c);
      logic [63:0] v;
      logic [1:0]  k;
      m_started = 1;
      if (m_names & NM_CL) begin
         if (m_vals[0] && c >= "0" && c <= "9") begin
            v = 64'(m_len) * 10 + 64'(c - "0");
            m_len = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
         end else begin
            m_vals = 0;
         end
      end else begin
         k = 0;
         if (m_vals[0] && char_at("close", m_pos, c)) k[0] = 1;
         if (m_vals[1] && char_at("chunked", m_pos, c)) k[1] = 1;
         m_vals = k;
      end
      m_pos = bump(m_pos);
   endtask

   task automatic new_name();
      m_names = 3'b111; m_pos = 0; m_cr = 0;
   endtask

   // advance the model by one accepted byte
   task automatic parse_byte(logic [7:0] c);
      logic [13:0] s;
      logic [2:0]  full;
      logic [7:0]  lc;
      logic [4:0]  d;
      case (m_phase)
         PH_PROTO: begin
            if (c == CH_SLASH) begin
               m_phase = (m_pos == 4) ? PH_VERSION : PH_STATUS;
               m_pos = 0;
            end else if (m_pos < 4 && char_at("http", m_pos, c)) begin
               m_pos++;
            end else begin
               m_pos = (to_lower(c) == CH_H) ? 5'd1 : 5'd0;
            end
         end
         PH_VERSION: if (c == CH_SPACE) begin
            m_phase = PH_STATUS; m_pos = 0;
         end
         PH_STATUS: begin
            if (c == CH_SPACE) begin
               m_phase = PH_DESC; m_pos = 0; m_cr = 0;
               push_event(EV_STATUS, 0);
            end else if (m_pos == 0 && c >= "0" && c <= "9") begin
               s = 14'(m_status) * 14'd10 + 14'(c - "0");
               m_status = (s > 14'd999) ? 10'd999 : s[9:0];
            end else begin
               m_pos = 1;
            end
         end
         PH_DESC: begin
            if (m_cr && c == CH_LF) begin
               m_phase = PH_KEY; new_name();
            end else begin
               m_cr = (c == CH_CR);
            end
         end
         PH_KEY: begin
            if (m_cr && c == CH_LF) begin
               m_cr = 0; m_count = 0; m_chunk = 0;
               m_phase = m_chunked ? PH_CLEN : PH_BODY;
               push_event(EV_HDR_DONE, 0);
               return;
            end
            if (m_cr) begin
               m_cr = 0;
               name_step(CH_CR);
            end else if (c == CH_CR && m_pos == 0) begin
               m_cr = 1;
               return;
            end
            if (c == CH_COLON) begin
               full = 0;
               if ((m_names & NM_CONN) && m_pos == 10) full = NM_CONN;
               if ((m_names & NM_TE) && m_pos == 17) full = NM_TE;
               if ((m_names & NM_CL) && m_pos == 14) full = NM_CL;
               m_names = full;
               if (full == NM_CL) m_len = 0;
               m_vals = 2'b11; m_started = 0; m_pos = 0; m_cr = 0;
               m_phase = PH_VALUE;
            end else begin
               name_step(c);
            end
         end
         PH_VALUE: begin
            if (m_cr && c == CH_LF) begin
               // header complete: apply connection / transfer-encoding
               if (m_names & NM_CONN) m_keep = !(m_vals[0] && m_pos == 5);
               else if ((m_names & NM_TE) && m_vals[1] && m_pos == 7) m_chunked = 1;
               m_phase = PH_KEY; new_name();
               return;
            end
            if (m_cr) begin
               m_cr = 0;
               value_step(CH_CR);
            end
            if (c == CH_CR) m_cr = 1;
            else if (!(c == CH_SPACE && !m_started)) value_step(c);
         end
         PH_BODY: begin
            if (m_len == 0) begin
               push_event(EV_BODY, c);
            end else begin
               m_count++;
               if (m_count >= m_len) begin
                  m_phase = PH_DONE;
                  push_event(EV_LAST, c);
               end else begin
                  push_event(EV_BODY, c);
               end
            end
         end
         PH_CLEN: begin
            if (m_cr && c == CH_LF) begin
               m_cr = 0;
               if (m_chunk == 0) begin
                  m_phase = PH_DONE;
                  push_event(EV_NO_DATA, 0);
               end else begin
                  m_count = 0; m_phase = PH_CDATA;
               end
               return;
            end
            m_cr = (c == CH_CR);
            lc = to_lower(c);
            d = 16;
            if (lc >= "0" && lc <= "9") d = lc - "0";
            else if (lc >= "a" && lc <= "f") d = lc - "a" + 10;
            if (d < 16)
               m_chunk = (m_chunk > 32'h0FFF_FFFF) ? 32'hFFFF_FFFF : {m_chunk[27:0], d[3:0]};
         end
         PH_CDATA: begin
            m_count++;
            if (m_count >= m_chunk) begin
               m_phase = PH_CTRAIL; m_pos = 0;
            end
            push_event(EV_BODY, c);
         end
         PH_CTRAIL: begin
            m_pos++;
            if (m_pos >= 2) begin
               m_pos = 0; m_chunk = 0; m_cr = 0; m_phase = PH_CLEN;
            end
         end
         default: ;
      endcase
   endtask

   // byte queue builders
   task automatic put_str(string s);
      foreach (s[i]) byte_queue.push_back({1'($urandom_range(0, 1)), s[i]});
   endtask

   function automatic string mixcase(string s);
      string r;
      r = s;
      foreach (r[i]) if ($urandom_range(0, 1) && r[i] >= "a" && r[i] <= "z") r[i] = r[i] - 8'd32;
      return r;
   endfunction

   task automatic put_random(int n);
      repeat (n) byte_queue.push_back(9'($urandom));
   endtask

   // driver: one beat at a time, random gaps, changes on falling edge
   int unsigned send_gap = 0;
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || sent_flag) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (byte_queue.size() > 0) begin
            {req_segment_last, req_data_byte} <= byte_queue.pop_front();
            req_valid <= 1'b1;
            send_gap <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 14) : 0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // accept tracker: model advances on each req beat
   always @(posedge clock) begin
      sent_flag <= 0;
      if (!reset && req_valid && req_ready) begin
         parse_byte(req_data_byte);
         sent_flag <= 1;
      end
   end

   // receiver: random stalls, plus one long hold-off to back up the pipeline
   int unsigned stall = 0;
   int unsigned hold_count = 0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (long_hold && hold_count < 300) begin
         hold_count <= hold_count + 1;
         rsp_ready <= 1'b0;
      end else if (stall > 0) begin
         stall <= stall - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 3) == 0) stall <= $urandom_range(0, 14);
      end
   end

   // monitor: compare each rsp beat with the oldest expected event
   always @(posedge clock) begin
      parse_event_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (event_queue.size() == 0) begin
            $display("%0t unexpected beat: actual ev %0d byte %h", $time, rsp_event_res,
                     rsp_body_byte);
            failures++;
         end else begin
            e = event_queue.pop_front();
            if ({rsp_event_res, rsp_body_byte, rsp_status_code, rsp_body_len,
                 rsp_chunked_mode, rsp_persist} !==
                {e.ev, e.body, e.status, e.clen, e.chunked, e.keep}) begin
               $display("%0t mismatch: expected ev %0d byte %h st %0d len %0d ch %b ka %b",
                        $time, e.ev, e.body, e.status, e.clen, e.chunked, e.keep);
               $display("%0t           actual ev %0d byte %h st %0d len %0d ch %b ka %b",
                        $time, rsp_event_res, rsp_body_byte, rsp_status_code,
                        rsp_body_len, rsp_chunked_mode, rsp_persist);
               failures++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      model_clear();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      // directed: broken protocol token, saturating length and chunk size
      put_str("xhttq/ ");
      put_str("12345 \r\r\n");
      put_str("content-length:99999999999\r\n");
      put_str({mixcase("transfer-encoding"), ":chunked\r\n"});
      put_str("Connection: close\r\n");
      put_str("\r\n");
      put_str("Fffffffff\r\n0\r\n");
      byte_queue.push_back(9'h1ff);
      byte_queue.push_back(9'h000);
      // long receiver hold while the sender keeps going
      long_hold = 1;
      // the saturated chunk size keeps the parser in chunk data, so the rest
      // of the stream comes back as body beats
      put_str("HTTP/1.0 200 ok\r\n");
      put_str("content-length: 250\r\n\r\n");
      put_random(250);
      // all bytes handed over and the last one taken
      while (byte_queue.size() > 0 || req_valid) @(posedge clock);
      while (event_queue.size() > 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (failures == 0 && event_queue.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end
endmodule

FILE: http_response_deframer_top.f
rtl/hrd_pkg.sv
rtl/hrd_front.sv
rtl/hrd_queue.sv
rtl/hrd_back.sv
rtl/http_response_deframer_top.sv
dv/tb.sv
